### rtl/cpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the polar curve point generator.
// No dependencies; cpg_ifs, cpg_cordic_cell and the top level import this package.

package cpg_pkg;

    localparam int PT_IDX_W   = 12;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 13;
    localparam int MODE_W     = 3;
    localparam int PETAL_W    = 8;
    localparam int ADDR_W     = 5;
    localparam int CW         = 34;   // CORDIC datapath width
    localparam int LIT_NUM_W  = 79;   // (a*a) << 16
    localparam int LIT_DEN_W  = 31;   // positive angle
    localparam int SQ_STEPS   = 32;
    localparam int PROD_W     = 67;   // radius product width
    localparam int PLACE_W    = 68;   // r * cos width

    localparam logic signed [CW-1:0]     GAIN_Q30     = 34'sd652032874;
    localparam logic signed [DATA_W-1:0] TURN_SCALE   = 32'sd683565276;
    localparam logic signed [67:0]       RADIUS_LIMIT = 68'sd4294967296;
    localparam logic signed [34:0]       ONE_Q30      = 35'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_SPIRAL   = 3'd0,
        MODE_CARDIOID = 3'd1,
        MODE_LIMACON  = 3'd2,
        MODE_ROSE     = 3'd3,
        MODE_LITUUS   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_COEF_A = 3'd1,
        REG_COEF_B = 3'd2,
        REG_PETAL  = 3'd3,
        REG_T0     = 3'd4,
        REG_T1     = 3'd5,
        REG_COUNT  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNDEF = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cvec;

    // sideband through the lituus divider
    typedef struct packed {
        logic [31:0]        phase;
        logic [31:0]        phk;
        logic signed [31:0] theta;
        logic               bad;
        logic               pos;
    } t_side_l;

    // sideband through the square root cells
    typedef struct packed {
        t_side_l l;
        logic    clamp;
    } t_side_s;

    // sideband through the CORDIC cells
    typedef struct packed {
        logic signed [31:0] theta;
        logic               bad;
        logic               pos;
        logic [32:0]        rlit;
        logic               lclamp;
        logic               flip_m;
        logic               flip_k;
    } t_side_c;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    function automatic t_cvec cordic_step(input t_cvec v, input int unsigned i);
        t_cvec                o;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        dx = v.y >>> i;
        dy = v.x >>> i;
        at = $signed({2'b00, ATAN_TURNS[i]});
        if (!v.z[CW-1]) begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - at;
        end else begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + at;
        end
        return o;
    endfunction

    function automatic t_sat sat32(input logic signed [37:0] v);
        t_sat o;
        if (v > 38'sd2147483647) begin
            o.ovf = 1'b1;
            o.val = 32'h7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            o.ovf = 1'b1;
            o.val = 32'h8000_0000;
        end else begin
            o.ovf = 1'b0;
            o.val = v[31:0];
        end
        return o;
    endfunction

endpackage

### rtl/cpg_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for point indices in and Cartesian points out.
// Depends on cpg_pkg.

interface cpg_in_if import cpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PT_IDX_W-1:0] point_index;

    modport source (output valid, output point_index, input ready);
    modport sink   (input valid, input point_index, output ready);
endinterface

interface cpg_out_if import cpg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic                     last;
    logic [1:0]               status;

    modport source (output valid, output pos_x, output pos_y, output last, output status,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input last, input status,
                    output ready);
endinterface

### rtl/cpg_div_cell.sv
`timescale 1ns / 1ps
// One restoring long-division step, registered: one quotient bit per cell.
// Standalone; carries a sideband vector alongside.

module cpg_div_cell #(
    parameter int NUM_W  = 44,
    parameter int DEN_W  = 13,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_acc,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_acc,
    output logic [DEN_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [NUM_W-1:0]  r_acc, n_acc;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_take;

    always_comb begin
        w_trial = {i_rem, i_acc[NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_take  = (w_trial >= {1'b0, i_den});
        n_rem   = w_take ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_acc   = {i_acc[NUM_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

### rtl/cpg_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit step of a 64-bit integer square root, registered.
// Standalone; BIT_EXP is the even bit weight that this cell tries.

module cpg_sqrt_cell #(
    parameter int BIT_EXP = 62,
    parameter int SIDE_W  = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_v,
    input  logic [63:0]       i_res,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [63:0]       o_v,
    output logic [63:0]       o_res,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic [63:0] TRY_BIT = 64'd1 << BIT_EXP;

    logic              r_valid;
    logic [63:0]       r_v, n_v;
    logic [63:0]       r_res, n_res;
    logic [SIDE_W-1:0] r_side;
    logic [64:0]       w_sum;
    logic              w_take;

    always_comb begin
        w_sum  = {1'b0, i_res} + {1'b0, TRY_BIT};
        w_take = ({1'b0, i_v} >= w_sum);
        n_v    = w_take ? (i_v - w_sum[63:0]) : i_v;
        n_res  = w_take ? ((i_res >> 1) + TRY_BIT) : (i_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_res  <= n_res;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_res   = r_res;
    assign o_side  = r_side;

endmodule

### rtl/cpg_cordic_cell.sv
`timescale 1ns / 1ps
// One registered CORDIC rotation step for the base angle and the rose angle.
// Depends on cpg_pkg (vector type, arctangent table, step function).

module cpg_cordic_cell import cpg_pkg::*; #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_cvec             i_m,
    input  t_cvec             i_k,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_cvec             o_m,
    output t_cvec             o_k,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    t_cvec             r_m, n_m;
    t_cvec             r_k, n_k;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        n_m = cordic_step(i_m, STAGE);
        n_k = cordic_step(i_k, STAGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_k    <= n_k;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_k     = r_k;
    assign o_side  = r_side;

endmodule

### rtl/polar_curve_point_generator.sv
`timescale 1ns / 1ps
// Polar curve point generator: index -> angle -> radius rule -> CORDIC -> Cartesian point.
// Throughput: one index per cycle while the output does not stall; in lituus the output
// register holds each result as two transactions and accepts no index until both go out.
// The pipeline length is set by the angle divider, the lituus divider and square root,
// and the CORDIC row. Reset (i_rst_n, synchronous) empties the pipe and loads defaults.
// Depends on cpg_pkg, cpg_ifs, cpg_div_cell, cpg_sqrt_cell, cpg_cordic_cell.

module polar_curve_point_generator import cpg_pkg::*; #(
    parameter int INDEX_BITS    = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpg_in_if.sink            i_pt,
    cpg_out_if.source         o_pt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int TD_N  = INDEX_BITS + 32;          // angle divider cells
    localparam int CMP_W = ((INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W) + 1;
    localparam int SL_W  = $bits(t_side_l);
    localparam int SS_W  = $bits(t_side_s);
    localparam int SC_W  = $bits(t_side_c);

    // ------------------------------------------------------------------
    // Configuration registers (APB). To be written only while the pipe is idle, so every
    // stage reads them directly; the user is bound by this, the block does not enforce it.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]        r_mode;
    logic signed [DATA_W-1:0] r_coef_a;
    logic signed [DATA_W-1:0] r_coef_b;
    logic [PETAL_W-1:0]       r_petal;
    logic signed [DATA_W-1:0] r_t0;
    logic signed [DATA_W-1:0] r_t1;
    logic [CNT_W-1:0]         r_count;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SPIRAL;
            r_coef_a <= 32'sd16384;
            r_coef_b <= 32'sd16384;
            r_petal  <= 8'd1;
            r_t0     <= 32'sd0;
            r_t1     <= 32'sd1310720;
            r_count  <= 13'd100;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_COEF_A: r_coef_a <= pwdata;
                REG_COEF_B: r_coef_b <= pwdata;
                REG_PETAL:  r_petal  <= pwdata[PETAL_W-1:0];
                REG_T0:     r_t0     <= pwdata;
                REG_T1:     r_t1     <= pwdata;
                REG_COUNT:  r_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:   prdata = {29'd0, r_mode};
            REG_COEF_A: prdata = r_coef_a;
            REG_COEF_B: prdata = r_coef_b;
            REG_PETAL:  prdata = {24'd0, r_petal};
            REG_T0:     prdata = r_t0;
            REG_T1:     prdata = r_t1;
            REG_COUNT:  prdata = {19'd0, r_count};
            default:    prdata = 32'd0;
        endcase
    end

    // Quantities that follow from the registers alone; they are registered and
    // settle in the cycle after a write, long before any item needs them.
    logic [31:0]       r_dmag;
    logic              r_dneg;
    logic [62:0]       r_lit_n;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_amag;
    logic [63:0]       w_asq;

    always_comb begin
        w_diff = 33'(r_t1) - 33'(r_t0);
        w_amag = r_coef_a[31] ? -33'(r_coef_a) : 33'(r_coef_a);
        w_asq  = w_amag[31:0] * w_amag[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_dneg  <= w_diff[32];
        r_dmag  <= w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
        r_lit_n <= w_asq[62:0];
    end

    // ------------------------------------------------------------------
    // Flow control: the whole row moves together. The output register
    // frees up once its last result transaction is taken.
    // ------------------------------------------------------------------
    logic w_en;
    logic r_ob_valid;
    logic r_ob_two;
    logic r_ob_second;
    logic w_ob_done;

    assign w_ob_done = o_pt.ready && (!r_ob_two || r_ob_second);
    assign w_en      = !r_ob_valid || w_ob_done;
    assign i_pt.ready = w_en;

    // ------------------------------------------------------------------
    // s0: capture index, range check. s1: |index * (end - start)|.
    // ------------------------------------------------------------------
    logic                  r_s0_valid, r_s1_valid;
    logic [INDEX_BITS-1:0] r_s0_idx;
    logic                  r_s0_bad, r_s1_bad;
    logic [TD_N-1:0]       r_s1_prod;
    logic [INDEX_BITS-1:0] w_idx;

    assign w_idx = INDEX_BITS'(i_pt.point_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_pt.valid;
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_idx  <= w_idx;
            r_s0_bad  <= (CMP_W'(w_idx) >= CMP_W'(r_count));
            r_s1_bad  <= r_s0_bad;
            r_s1_prod <= TD_N'(r_s0_idx) * TD_N'(r_dmag);
        end
    end

    // ------------------------------------------------------------------
    // Angle divider: one quotient bit per cell, divisor is point_count.
    // ------------------------------------------------------------------
    logic             w_td_v    [0:TD_N];
    logic [TD_N-1:0]  w_td_acc  [0:TD_N];
    logic [CNT_W-1:0] w_td_rem  [0:TD_N];
    logic [CNT_W-1:0] w_td_den  [0:TD_N];
    logic [0:0]       w_td_side [0:TD_N];

    assign w_td_v[0]    = r_s1_valid;
    assign w_td_acc[0]  = r_s1_prod;
    assign w_td_rem[0]  = '0;
    assign w_td_den[0]  = r_count;
    assign w_td_side[0] = r_s1_bad;

    for (genvar g = 0; g < TD_N; g++) begin : g_td
        cpg_div_cell #(
            .NUM_W  (TD_N),
            .DEN_W  (CNT_W),
            .SIDE_W (1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_td_v[g]),
            .i_acc   (w_td_acc[g]),
            .i_rem   (w_td_rem[g]),
            .i_den   (w_td_den[g]),
            .i_side  (w_td_side[g]),
            .o_valid (w_td_v[g+1]),
            .o_acc   (w_td_acc[g+1]),
            .o_rem   (w_td_rem[g+1]),
            .o_den   (w_td_den[g+1]),
            .o_side  (w_td_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // T: theta = start + signed quotient. P: phase in 2^-32 turn.
    // K: rose phase = phase * k, positivity for lituus.
    // ------------------------------------------------------------------
    logic               r_t_valid, r_p_valid, r_k_valid;
    logic signed [31:0] r_t_theta, r_p_theta, r_k_theta;
    logic               r_t_bad, r_p_bad, r_k_bad;
    logic [31:0]        r_p_phase, r_k_phase, r_k_phk;
    logic               r_k_pos;
    logic [32:0]        w_q;
    logic signed [33:0] w_theta;
    logic signed [63:0] w_tprod;

    always_comb begin
        w_q     = w_td_acc[TD_N][32:0];
        w_theta = 34'(r_t0) + (r_dneg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q}));
        w_tprod = r_t_theta * TURN_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else if (w_en) begin
            r_t_valid <= w_td_v[TD_N];
            r_p_valid <= r_t_valid;
            r_k_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_theta <= w_theta[31:0];
            r_t_bad   <= w_td_side[TD_N][0];
            r_p_theta <= r_t_theta;
            r_p_bad   <= r_t_bad;
            r_p_phase <= w_tprod[47:16];
            r_k_theta <= r_p_theta;
            r_k_bad   <= r_p_bad;
            r_k_phase <= r_p_phase;
            r_k_phk   <= r_p_phase * {24'd0, r_petal};
            r_k_pos   <= !r_p_theta[31] && (r_p_theta != 32'sd0);
        end
    end

    // ------------------------------------------------------------------
    // Lituus divider: floor((a*a << 16) / theta), one bit per cell.
    // Runs for every item; other modes simply ignore the result.
    // ------------------------------------------------------------------
    logic                 w_ld_v    [0:LIT_NUM_W];
    logic [LIT_NUM_W-1:0] w_ld_acc  [0:LIT_NUM_W];
    logic [LIT_DEN_W-1:0] w_ld_rem  [0:LIT_NUM_W];
    logic [LIT_DEN_W-1:0] w_ld_den  [0:LIT_NUM_W];
    t_side_l              w_ld_side [0:LIT_NUM_W];

    assign w_ld_v[0]          = r_k_valid;
    assign w_ld_acc[0]        = {r_lit_n, 16'd0};
    assign w_ld_rem[0]        = '0;
    assign w_ld_den[0]        = r_k_theta[LIT_DEN_W-1:0];
    assign w_ld_side[0].phase = r_k_phase;
    assign w_ld_side[0].phk   = r_k_phk;
    assign w_ld_side[0].theta = r_k_theta;
    assign w_ld_side[0].bad   = r_k_bad;
    assign w_ld_side[0].pos   = r_k_pos;

    for (genvar g = 0; g < LIT_NUM_W; g++) begin : g_ld
        cpg_div_cell #(
            .NUM_W  (LIT_NUM_W),
            .DEN_W  (LIT_DEN_W),
            .SIDE_W (SL_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_ld_v[g]),
            .i_acc   (w_ld_acc[g]),
            .i_rem   (w_ld_rem[g]),
            .i_den   (w_ld_den[g]),
            .i_side  (w_ld_side[g]),
            .o_valid (w_ld_v[g+1]),
            .o_acc   (w_ld_acc[g+1]),
            .o_rem   (w_ld_rem[g+1]),
            .o_den   (w_ld_den[g+1]),
            .o_side  (w_ld_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Square root of the 64-bit quotient; quotient of 2^64 or more clamps
    // the radius to 2^32.
    // ------------------------------------------------------------------
    logic        w_sq_v    [0:SQ_STEPS];
    logic [63:0] w_sq_val  [0:SQ_STEPS];
    logic [63:0] w_sq_res  [0:SQ_STEPS];
    t_side_s     w_sq_side [0:SQ_STEPS];

    assign w_sq_v[0]          = w_ld_v[LIT_NUM_W];
    assign w_sq_val[0]        = w_ld_acc[LIT_NUM_W][63:0];
    assign w_sq_res[0]        = '0;
    assign w_sq_side[0].l     = w_ld_side[LIT_NUM_W];
    assign w_sq_side[0].clamp = |w_ld_acc[LIT_NUM_W][LIT_NUM_W-1:64];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        cpg_sqrt_cell #(
            .BIT_EXP (62 - 2 * g),
            .SIDE_W  (SS_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_v     (w_sq_val[g]),
            .i_res   (w_sq_res[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_v     (w_sq_val[g+1]),
            .o_res   (w_sq_res[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // CORDIC row: base angle and rose angle side by side. Phases in the
    // left half-plane are turned by half a turn; the result is negated
    // after the row. Bits 31 and 30 of the phase decide the flip.
    // ------------------------------------------------------------------
    logic    w_cr_v    [0:CORDIC_STAGES];
    t_cvec   w_cr_m    [0:CORDIC_STAGES];
    t_cvec   w_cr_k    [0:CORDIC_STAGES];
    t_side_c w_cr_side [0:CORDIC_STAGES];
    t_side_s w_sq_out;
    logic    w_fm, w_fk;

    assign w_sq_out = w_sq_side[SQ_STEPS];
    assign w_fm     = w_sq_out.l.phase[31] ^ w_sq_out.l.phase[30];
    assign w_fk     = w_sq_out.l.phk[31] ^ w_sq_out.l.phk[30];

    assign w_cr_v[0]   = w_sq_v[SQ_STEPS];
    assign w_cr_m[0].x = GAIN_Q30;
    assign w_cr_m[0].y = '0;
    assign w_cr_m[0].z = $signed({{3{w_sq_out.l.phase[30]}}, w_sq_out.l.phase[30:0]});
    assign w_cr_k[0].x = GAIN_Q30;
    assign w_cr_k[0].y = '0;
    assign w_cr_k[0].z = $signed({{3{w_sq_out.l.phk[30]}}, w_sq_out.l.phk[30:0]});

    assign w_cr_side[0].theta  = w_sq_out.l.theta;
    assign w_cr_side[0].bad    = w_sq_out.l.bad;
    assign w_cr_side[0].pos    = w_sq_out.l.pos;
    assign w_cr_side[0].rlit   = w_sq_out.clamp ? 33'h1_0000_0000 : w_sq_res[SQ_STEPS][32:0];
    assign w_cr_side[0].lclamp = w_sq_out.clamp;
    assign w_cr_side[0].flip_m = w_fm;
    assign w_cr_side[0].flip_k = w_fk;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cr
        cpg_cordic_cell #(
            .STAGE  (g),
            .SIDE_W (SC_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cr_v[g]),
            .i_m     (w_cr_m[g]),
            .i_k     (w_cr_k[g]),
            .i_side  (w_cr_side[g]),
            .o_valid (w_cr_v[g+1]),
            .o_m     (w_cr_m[g+1]),
            .o_k     (w_cr_k[g+1]),
            .o_side  (w_cr_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // CQ: undo the half-turn flip, precompute 1 + cos for the cardioid.
    // ------------------------------------------------------------------
    t_side_c              w_cr_out;
    logic                 r_cq_valid;
    logic signed [CW-1:0] r_cq_c, r_cq_s, r_cq_ck;
    logic signed [34:0]   r_cq_onec;
    t_side_c              r_cq_side;
    t_cvec                w_cm, w_ck;
    logic signed [CW-1:0] w_c;

    always_comb begin
        w_cr_out = w_cr_side[CORDIC_STAGES];
        w_cm     = w_cr_m[CORDIC_STAGES];
        w_ck     = w_cr_k[CORDIC_STAGES];
        w_c      = w_cr_out.flip_m ? -w_cm.x : w_cm.x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cq_valid <= 1'b0;
        end else if (w_en) begin
            r_cq_valid <= w_cr_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cq_c    <= w_c;
            r_cq_s    <= w_cr_out.flip_m ? -w_cm.y : w_cm.y;
            r_cq_ck   <= w_cr_out.flip_k ? -w_ck.x : w_ck.x;
            r_cq_onec <= ONE_Q30 + 35'(w_c);
            r_cq_side <= w_cr_out;
        end
    end

    // ------------------------------------------------------------------
    // M1: the one radius multiply, operands picked by mode.
    //   spiral  b*theta >> 16 + a     cardioid a*(1+cos) >> 30
    //   limacon b*cos   >> 30 + a     rose     a*cos(k theta) >> 30
    // ------------------------------------------------------------------
    logic                       r_m1_valid;
    logic signed [PROD_W-1:0]   r_m1_prod;
    logic signed [DATA_W-1:0]   r_m1_add;
    logic                       r_m1_sh30;
    logic signed [CW-1:0]       r_m1_c, r_m1_s;
    t_side_c                    r_m1_side;
    logic signed [DATA_W-1:0]   w_op1, w_add;
    logic signed [34:0]         w_op2;
    logic                       w_sh30;

    always_comb begin
        case (r_mode)
            MODE_CARDIOID: begin
                w_op1  = r_coef_a;
                w_op2  = r_cq_onec;
                w_add  = '0;
                w_sh30 = 1'b1;
            end
            MODE_LIMACON: begin
                w_op1  = r_coef_b;
                w_op2  = 35'(r_cq_c);
                w_add  = r_coef_a;
                w_sh30 = 1'b1;
            end
            MODE_ROSE: begin
                w_op1  = r_coef_a;
                w_op2  = 35'(r_cq_ck);
                w_add  = '0;
                w_sh30 = 1'b1;
            end
            default: begin
                w_op1  = r_coef_b;
                w_op2  = 35'(r_cq_side.theta);
                w_add  = r_coef_a;
                w_sh30 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= r_cq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_prod <= w_op1 * w_op2;
            r_m1_add  <= w_add;
            r_m1_sh30 <= w_sh30;
            r_m1_c    <= r_cq_c;
            r_m1_s    <= r_cq_s;
            r_m1_side <= r_cq_side;
        end
    end

    // ------------------------------------------------------------------
    // M2: radius, clamped to +-2^32 (lituus radius comes from the root).
    // ------------------------------------------------------------------
    logic                 r_m2_valid;
    logic signed [33:0]   r_m2_r;
    logic                 r_m2_clamp;
    logic signed [CW-1:0] r_m2_c, r_m2_s;
    logic                 r_m2_bad, r_m2_pos;
    logic signed [67:0]   w_rfull;
    logic signed [33:0]   w_r;
    logic                 w_clamp;

    always_comb begin
        w_rfull = 68'(r_m1_sh30 ? (r_m1_prod >>> 30) : (r_m1_prod >>> 16)) + 68'(r_m1_add);
        if (r_mode == MODE_LITUUS) begin
            w_r     = $signed({1'b0, r_m1_side.rlit});
            w_clamp = r_m1_side.lclamp;
        end else if (w_rfull > RADIUS_LIMIT) begin
            w_r     = 34'(RADIUS_LIMIT);
            w_clamp = 1'b1;
        end else if (w_rfull < -RADIUS_LIMIT) begin
            w_r     = -34'(RADIUS_LIMIT);
            w_clamp = 1'b1;
        end else begin
            w_r     = w_rfull[33:0];
            w_clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_r     <= w_r;
            r_m2_clamp <= w_clamp;
            r_m2_c     <= r_m1_c;
            r_m2_s     <= r_m1_s;
            r_m2_bad   <= r_m1_side.bad;
            r_m2_pos   <= r_m1_side.pos;
        end
    end

    // ------------------------------------------------------------------
    // M3: r*cos and r*sin.
    // ------------------------------------------------------------------
    logic                      r_m3_valid;
    logic signed [PLACE_W-1:0] r_m3_px, r_m3_py;
    logic                      r_m3_clamp, r_m3_bad, r_m3_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (w_en) begin
            r_m3_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3_px    <= r_m2_r * r_m2_c;
            r_m3_py    <= r_m2_r * r_m2_s;
            r_m3_clamp <= r_m2_clamp;
            r_m3_bad   <= r_m2_bad;
            r_m3_pos   <= r_m2_pos;
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor >> 30, saturate, special cases. Lituus holds
    // the -r point as a second transaction.
    // ------------------------------------------------------------------
    logic [31:0]               r_ob_x1, r_ob_y1, r_ob_x2, r_ob_y2;
    logic [1:0]                r_ob_st1, r_ob_st2;
    logic [31:0]               n_x1, n_y1, n_x2, n_y2;
    logic [1:0]                n_st1, n_st2;
    logic                      n_two;
    logic signed [PLACE_W-1:0] w_npx, w_npy;
    t_sat                      w_sx1, w_sy1, w_sx2, w_sy2;

    always_comb begin
        w_npx = -r_m3_px;
        w_npy = -r_m3_py;
        w_sx1 = sat32(38'(r_m3_px >>> 30));
        w_sy1 = sat32(38'(r_m3_py >>> 30));
        w_sx2 = sat32(38'(w_npx >>> 30));
        w_sy2 = sat32(38'(w_npy >>> 30));
        n_x1  = w_sx1.val;
        n_y1  = w_sy1.val;
        n_x2  = w_sx2.val;
        n_y2  = w_sy2.val;
        n_st1 = (r_m3_clamp || w_sx1.ovf || w_sy1.ovf) ? ST_SAT : ST_OK;
        n_st2 = (r_m3_clamp || w_sx2.ovf || w_sy2.ovf) ? ST_SAT : ST_OK;
        n_two = (r_mode == MODE_LITUUS);
        if (r_m3_bad) begin
            n_x1  = '0;
            n_y1  = '0;
            n_st1 = ST_RANGE;
            n_two = 1'b0;
        end else if (n_two && !r_m3_pos) begin
            n_x1  = '0;
            n_y1  = '0;
            n_x2  = '0;
            n_y2  = '0;
            n_st1 = ST_UNDEF;
            n_st2 = ST_UNDEF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid  <= 1'b0;
            r_ob_two    <= 1'b0;
            r_ob_second <= 1'b0;
        end else if (w_en) begin
            r_ob_valid  <= r_m3_valid;
            r_ob_two    <= n_two;
            r_ob_second <= 1'b0;
        end else if (o_pt.ready) begin
            r_ob_second <= 1'b1;     // first of a pair taken
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ob_x1  <= n_x1;
            r_ob_y1  <= n_y1;
            r_ob_x2  <= n_x2;
            r_ob_y2  <= n_y2;
            r_ob_st1 <= n_st1;
            r_ob_st2 <= n_st2;
        end
    end

    assign o_pt.valid  = r_ob_valid;
    assign o_pt.pos_x  = r_ob_second ? r_ob_x2 : r_ob_x1;
    assign o_pt.pos_y  = r_ob_second ? r_ob_y2 : r_ob_y1;
    assign o_pt.last   = !r_ob_two || r_ob_second;
    assign o_pt.status = r_ob_second ? r_ob_st2 : r_ob_st1;

endmodule
